// ----- src/cpid_pkg.sv -----
// Shared types, register codes and the symmetric clamp for the clamped PID block.
`timescale 1ns / 1ps

package cpid_pkg;

   // Sample and result widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int FRAC_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default divide ratio applied to the measured sample
   localparam int MEAS_DIV_DEF = 1;

   // Width of a clamped term: limit scaled by the fraction bits, plus sign
   localparam int TERM_W  = LIMIT_W + FRAC_W + 1;
   // Width handed to the clamp function
   localparam int CLAMP_W = 36;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [TERM_W-1:0]   term_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P    = 3'd0,
      REG_GAIN_I    = 3'd1,
      REG_GAIN_D    = 3'd2,
      REG_LIMIT_P   = 3'd3,
      REG_LIMIT_I   = 3'd4,
      REG_LIMIT_D   = 3'd5,
      REG_LIMIT_OUT = 3'd6,
      REG_DEADBAND  = 3'd7
   } reg_index_type;

   // Clamp a value to +/- (limit * 256)
   function automatic term_type clamp_sym(input logic signed [CLAMP_W-1:0] value,
                                          input logic [LIMIT_W-1:0] limit);
      logic signed [CLAMP_W-1:0] pos_lim;
      logic signed [CLAMP_W-1:0] neg_lim;
      logic signed [CLAMP_W-1:0] res;
      pos_lim = $signed({{(CLAMP_W-LIMIT_W-FRAC_W){1'b0}}, limit, {FRAC_W{1'b0}}});
      neg_lim = -pos_lim;
      if (value > pos_lim) begin
         res = pos_lim;
      end else if (value < neg_lim) begin
         res = neg_lim;
      end else begin
         res = value;
      end
      return res[TERM_W-1:0];
   endfunction

endpackage

// ----- src/cpid_req_if.sv -----
// Request channel interface: one control tick of measured, target and compensation.
`timescale 1ns / 1ps

interface cpid_req_if
   import cpid_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type measured;
   sample_type target;
   sample_type compensation;

   modport source (output valid, output measured, output target, output compensation,
                   input ready);
   modport sink   (input valid, input measured, input target, input compensation,
                   output ready);
endinterface

// ----- src/cpid_rsp_if.sv -----
// Result channel interface: one clamped drive value per tick.
`timescale 1ns / 1ps

interface cpid_rsp_if
   import cpid_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// ----- src/clamped_pid_with_deadband_top.sv -----
// Top level of the clamped PID controller with error deadband.
//
//  channel   | direction | transfer when        | payload
//  ----------+-----------+----------------------+-----------------------------------
//  req_chan  | in        | valid && ready       | measured, target, compensation
//  rsp_chan  | out       | valid && ready       | drive
//  csr_*     | in        | csr_we               | csr_index, csr_wdata (no read-back)
//
// Seven register stages: input, reciprocal product, quotient, deadband error,
// gain products, clamped terms, result. One tick enters per cycle unless a stalled
// result has backed the pipeline up to the input stage.
// The integrator loop (add and clamp) closes within the terms stage.
// Synchronous reset clears the stage valids, integrator, last error and configuration registers.
// A stalled result holds; earlier stages keep filling bubbles until full.
`timescale 1ns / 1ps

module clamped_pid_with_deadband_top
   import cpid_pkg::*;
#(
   parameter int MEAS_DIV = MEAS_DIV_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cpid_req_if.sink              req_chan,
   cpid_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Divide by the ratio as a multiply by a truncated reciprocal, then one correction
   localparam int RECIP_SHIFT = SAMPLE_W;
   localparam int RECIP_W     = SAMPLE_W + 1;
   localparam int RATIO_W     = 7;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / MEAS_DIV);
   localparam logic [RATIO_W-1:0] RATIO = RATIO_W'(MEAS_DIV);
   localparam int PROD_W      = SAMPLE_W + RECIP_W;
   localparam int ERR_W       = SAMPLE_W + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int PI_W        = ERR_W + GAIN_W;
   localparam int PD_W        = DIFF_W + GAIN_W;
   localparam int INTEG_W     = TERM_W + 1;
   localparam int SUM_W       = TERM_W + 3;

   // Configuration registers
   logic signed [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIMIT_W-1:0] limit_p_ff, limit_i_ff, limit_d_ff, limit_out_ff, deadband_ff;

   // Stage valids and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic en1, en2, en3, en4, en5, en6, en7;

   // Stage 1: input register
   sample_type meas1_ff, tgt1_ff, comp1_ff;
   // Stage 2: magnitude and reciprocal product
   logic [SAMPLE_W-1:0] mag2_ff, mag2_in;
   logic [SAMPLE_W-1:0] q2_ff, q2_in;
   logic                neg2_ff;
   sample_type          tgt2_ff, comp2_ff;
   logic [PROD_W-1:0]   recip_prod;
   // Stage 3: corrected signed quotient
   sample_type          meas3_ff, meas3_in;
   sample_type          tgt3_ff, comp3_ff;
   logic [PROD_W-1:0]   q_times_r;
   logic [SAMPLE_W:0]   remainder;
   logic [SAMPLE_W:0]   q_fixed;
   logic [SAMPLE_W:0]   q_signed;
   // Stage 4: error after deadband
   logic signed [ERR_W-1:0] err4_ff, err4_in;
   logic signed [ERR_W-1:0] err_raw, err_mag, db_ext;
   sample_type              comp4_ff;
   // Stage 5: gain products and last error
   logic signed [PI_W-1:0]   prod_p5_ff, prod_p5_in;
   logic signed [PI_W-1:0]   prod_i5_ff, prod_i5_in;
   logic signed [PD_W-1:0]   prod_d5_ff, prod_d5_in;
   logic signed [DIFF_W-1:0] err_diff;
   logic signed [ERR_W-1:0]  prev_err_ff;
   sample_type               comp5_ff;
   // Stage 6: clamped terms and integrator
   term_type                   pterm6_ff, pterm6_in;
   term_type                   dterm6_ff, dterm6_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [CLAMP_W-1:0]  integ_sum;
   sample_type                 comp6_ff;
   // Stage 7: result register
   logic signed [SUM_W-1:0] total;
   term_type                total_clamped;
   sample_type              drive7_ff, drive7_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         limit_p_ff   <= '0;
         limit_i_ff   <= '0;
         limit_d_ff   <= '0;
         limit_out_ff <= '0;
         deadband_ff  <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_GAIN_P:    gain_p_ff    <= csr_wdata;
            REG_GAIN_I:    gain_i_ff    <= csr_wdata;
            REG_GAIN_D:    gain_d_ff    <= csr_wdata;
            REG_LIMIT_P:   limit_p_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_LIMIT_I:   limit_i_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_LIMIT_D:   limit_d_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_LIMIT_OUT: limit_out_ff <= csr_wdata[LIMIT_W-1:0];
            REG_DEADBAND:  deadband_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or its contents move on
   assign en7 = !v7_ff || rsp_chan.ready;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1;
   assign rsp_chan.valid = v7_ff;
   assign rsp_chan.drive = drive7_ff;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   // Magnitude of the measured sample times the reciprocal of the ratio
   always_comb begin
      mag2_in    = meas1_ff[SAMPLE_W-1] ? SAMPLE_W'(-meas1_ff) : SAMPLE_W'(meas1_ff);
      recip_prod = PROD_W'(mag2_in) * PROD_W'(RECIP);
      q2_in      = recip_prod[RECIP_SHIFT +: SAMPLE_W];
   end

   // Correct the quotient by one and restore the sign (truncation toward zero)
   always_comb begin
      q_times_r = PROD_W'(q2_ff) * PROD_W'(RATIO);
      remainder = {1'b0, mag2_ff} - q_times_r[SAMPLE_W:0];
      q_fixed   = (remainder >= (SAMPLE_W+1)'(RATIO)) ? {1'b0, q2_ff} + 1'b1 : {1'b0, q2_ff};
      q_signed  = neg2_ff ? -q_fixed : q_fixed;
      meas3_in  = q_signed[SAMPLE_W-1:0];
   end

   // Form the error and pull it through the deadband
   always_comb begin
      err_raw = ERR_W'(tgt3_ff) - ERR_W'(meas3_ff);
      err_mag = err_raw[ERR_W-1] ? -err_raw : err_raw;
      db_ext  = $signed({{(ERR_W-LIMIT_W){1'b0}}, deadband_ff});
      if (err_mag < db_ext) begin
         err4_in = '0;
      end else if (err_raw[ERR_W-1]) begin
         err4_in = err_raw + db_ext;
      end else begin
         err4_in = err_raw - db_ext;
      end
   end

   // Gain products
   always_comb begin
      err_diff   = DIFF_W'(err4_ff) - DIFF_W'(prev_err_ff);
      prod_p5_in = PI_W'(gain_p_ff) * PI_W'(err4_ff);
      prod_i5_in = PI_W'(gain_i_ff) * PI_W'(err4_ff);
      prod_d5_in = PD_W'(gain_d_ff) * PD_W'(err_diff);
   end

   // Clamp the terms; accumulate and clamp the integrator
   always_comb begin
      pterm6_in = clamp_sym(CLAMP_W'(prod_p5_ff), limit_p_ff);
      dterm6_in = clamp_sym(CLAMP_W'(prod_d5_ff), limit_d_ff);
      integ_sum = CLAMP_W'(integ_ff) + CLAMP_W'(prod_i5_ff);
      integ_in  = INTEG_W'(clamp_sym(integ_sum, limit_i_ff));
   end

   // Sum with compensation, clamp and drop the fraction bits (floor)
   always_comb begin
      total = SUM_W'(pterm6_ff) + SUM_W'(integ_ff) + SUM_W'(dterm6_ff)
            + $signed({{(SUM_W-SAMPLE_W-FRAC_W){comp6_ff[SAMPLE_W-1]}}, comp6_ff,
                       {FRAC_W{1'b0}}});
      total_clamped = clamp_sym(CLAMP_W'(total), limit_out_ff);
      drive7_in     = total_clamped[FRAC_W +: SAMPLE_W];
   end

   // Loop state: integrator and last error
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else begin
         if (en5 && v4_ff) prev_err_ff <= err4_ff;
         if (en6 && v5_ff) integ_ff    <= integ_in;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (en1) begin
         meas1_ff <= req_chan.measured;
         tgt1_ff  <= req_chan.target;
         comp1_ff <= req_chan.compensation;
      end
      if (en2) begin
         mag2_ff  <= mag2_in;
         q2_ff    <= q2_in;
         neg2_ff  <= meas1_ff[SAMPLE_W-1];
         tgt2_ff  <= tgt1_ff;
         comp2_ff <= comp1_ff;
      end
      if (en3) begin
         meas3_ff <= meas3_in;
         tgt3_ff  <= tgt2_ff;
         comp3_ff <= comp2_ff;
      end
      if (en4) begin
         err4_ff  <= err4_in;
         comp4_ff <= comp3_ff;
      end
      if (en5) begin
         prod_p5_ff <= prod_p5_in;
         prod_i5_ff <= prod_i5_in;
         prod_d5_ff <= prod_d5_in;
         comp5_ff   <= comp4_ff;
      end
      if (en6) begin
         pterm6_ff <= pterm6_in;
         dterm6_ff <= dterm6_in;
         comp6_ff  <= comp5_ff;
      end
      if (en7) begin
         drive7_ff <= drive7_in;
      end
   end

endmodule
